@@ hdl/wpc_pkg.sv @@
// Shared types, constants and control records of the waypoint controller.
package wpc_pkg;

    // Field widths
    localparam int POS_BITS   = 24;
    localparam int DIFF_W     = POS_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int ROOT_W     = PROD_W / 2;
    localparam int EL_W       = 20;
    localparam int DIST_W     = 48;
    localparam int TIME_W     = 40;
    localparam int SEQ_W      = 32;
    localparam int GAIN_W     = 8;
    localparam int CFG_W      = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int OP_W       = 2;
    localparam int S_DATA_W   = ((3 * POS_BITS + EL_W + 7) / 8) * 8;

    localparam int MAX_GOALS_DEF = 16;

    // Operation codes on s_tuser
    localparam logic [OP_W-1:0] OP_ODOM   = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_TOL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIMB     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR  = 3'd5;

    // Register reset values
    localparam logic [GAIN_W-1:0] RST_P_GAIN    = 8'd128;
    localparam logic [CFG_W-1:0]  RST_MAX_SPEED = 23'd65536;
    localparam logic [CFG_W-1:0]  RST_GOAL_TOL  = 23'd32768;
    localparam logic [CFG_W-1:0]  RST_TAKEOFF_H = 23'd32768;
    localparam logic [CFG_W-1:0]  RST_CLIMB     = 23'd6554;
    localparam logic [CFG_W-1:0]  RST_MOVE_THR  = 23'd655;

    // Axis indexes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_SQE, ST_RINIT, ST_ROOT, ST_ACC,
        ST_MODE, ST_GRD, ST_GX, ST_GY, ST_GZ, ST_GT, ST_GE, ST_GRD2,
        ST_DX, ST_DY, ST_DZ, ST_DE, ST_EM_TO, ST_EM_HV, ST_EM_DRV
    } state_t;

    typedef enum logic [1:0] {
        MS_STEP, MS_GOAL, MS_TOL, MS_GAIN
    } mul_src_t;

    typedef enum logic [1:0] {
        EM_NONE, EM_TAKEOFF, EM_HOVER, EM_DRIVE
    } emit_t;

    typedef struct packed {
        logic       in_ready;
        logic       mul_en;
        mul_src_t   mul_src;
        logic [1:0] mul_axis;
        logic       acc_load;
        logic       acc_add;
        logic       root_init;
        logic       root_step;
        logic       upd_sums;
        logic       set_airborne;
        logic       goal_rd;
        logic       adv_ptr;
        logic       set_idle;
        logic       drv_store;
        logic [1:0] store_axis;
        emit_t      emit;
    } cmd_t;

    typedef struct packed {
        logic odom_req;
        logic first_sample;
        logic airborne;
        logic below_takeoff;
        logic goal_active;
        logic near;
        logic last_goal;
        logic out_free;
        logic root_last;
        logic ptr_ok;
    } status_t;

endpackage

@@ hdl/waypoint_p_controller.sv @@
// Waypoint proportional controller: top level joining sequencer and datapath.
//
// Input stream s_*: s_tuser carries the operation (odometry sample, append
// goal, clear goals); s_tdata carries x, y, z and elapsed microseconds.
// Append and clear take effect in the cycle they are accepted and can follow
// back to back. An odometry request occupies the block: s_tready stays low
// until it completes. Configuration writes go over cfg_*; the user must make
// them only while it is idle, as the block itself does not enforce it.
// Result stream m_*: at most one command per odometry request, held in an
// output register; the next request is accepted while it waits. The step is
// squared on a shared 25x25 multiplier used one axis per cycle (SQX, SQY,
// SQZ, SQE), the 25-step bit-serial square root of the step length is taken
// (RINIT, ROOT), the sums updated (ACC) and the mode picked (MODE); the
// first sample starts at ACC. Steering reads and tests the goal (GRD, GX,
// GY, GZ, GT, GE), reads the next goal (GRD2) once one is reached, and
// scales the drive (DX, DY, DZ, DE). s_tready returns with the sequencer in
// idle. A full output register holds the sequencer in its emit state until
// m_tready. Reset (aresetn low, synchronous) empties the goal list, clears
// the sums and counter, resets the flags and restores the register defaults.
module waypoint_p_controller #(
    parameter int MAX_GOALS = wpc_pkg::MAX_GOALS_DEF,
    localparam int CNT_W    = $clog2(MAX_GOALS + 1),
    localparam int OUT_W    = wpc_pkg::SEQ_W + 3 * wpc_pkg::POS_BITS + 1 + CNT_W
                              + wpc_pkg::DIST_W + wpc_pkg::TIME_W,
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x, pos_y, pos_z, elapsed_us (lowest first), zero padded
    input  logic [wpc_pkg::S_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [wpc_pkg::OP_W-1:0]      s_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wpc_pkg::CFG_W-1:0]     cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // sequence_res, move_forward, move_left, move_up, mission_idle,
    // goal_number, path_length, moving_time_us (lowest first), zero padded
    output logic [M_DATA_W-1:0]           m_tdata,
    // takeoff_request
    output logic                          m_tuser
);
    wpc_pkg::cmd_t    cmd;
    wpc_pkg::status_t st;

    assign s_tready  = cmd.in_ready;
    assign cfg_ready = 1'b1;

    wpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cmd     (cmd)
    );

    wpc_dpath #(.MAX_GOALS(MAX_GOALS)) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // An odometry request holds off the next one
    a_odom_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == wpc_pkg::OP_ODOM |=> !s_tready)
        else $error("input accepted while odometry request in progress");

    // The goal pointer never passes the goal count
    a_ptr_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        st.ptr_ok)
        else $error("goal pointer beyond goal count");

    // A command emitted while the output is stalled keeps m_tvalid high
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit != wpc_pkg::EM_NONE && !st.out_free |=> m_tvalid)
        else $error("pending command lost while output stalled");
`endif
endmodule

@@ hdl/wpc_sqrt.sv @@
// Bit-serial integer square root, one result bit per cycle in which step is high.
module wpc_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        init,
    input  logic                        step,
    input  logic [wpc_pkg::PROD_W-1:0]  radicand,
    output logic [wpc_pkg::ROOT_W-1:0]  root,
    output logic                        last
);
    localparam int CNT_W = $clog2(wpc_pkg::ROOT_W);

    logic [wpc_pkg::PROD_W-1:0] rad_reg;
    logic [wpc_pkg::ROOT_W+1:0] rem_reg;
    logic [wpc_pkg::ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [wpc_pkg::ROOT_W+1:0] rem_try;
    logic [wpc_pkg::ROOT_W+1:0] trial;
    logic                       fits;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        rem_try = {rem_reg[wpc_pkg::ROOT_W-1:0],
                   rad_reg[wpc_pkg::PROD_W-1 -: 2]};
        trial   = {root_reg, 2'b01};
        fits    = (rem_try >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (init) begin
            cnt_reg <= '0;
        end else if (step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (init) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (step) begin
            rad_reg  <= {rad_reg[wpc_pkg::PROD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_try - trial) : rem_try;
            root_reg <= {root_reg[wpc_pkg::ROOT_W-2:0], fits};
        end
    end

    assign root = root_reg;
    assign last = (cnt_reg == CNT_W'(wpc_pkg::ROOT_W - 1));
endmodule

@@ hdl/wpc_ctrl.sv @@
// Sequencer that steps the waypoint datapath through one odometry request.
module wpc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  wpc_pkg::status_t  st,
    output wpc_pkg::cmd_t     cmd
);
    wpc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wpc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wpc_pkg::ST_IDLE: begin
                if (st.odom_req) begin
                    state_next = st.first_sample ? wpc_pkg::ST_ACC : wpc_pkg::ST_SQX;
                end
            end
            wpc_pkg::ST_SQX:   state_next = wpc_pkg::ST_SQY;
            wpc_pkg::ST_SQY:   state_next = wpc_pkg::ST_SQZ;
            wpc_pkg::ST_SQZ:   state_next = wpc_pkg::ST_SQE;
            wpc_pkg::ST_SQE:   state_next = wpc_pkg::ST_RINIT;
            wpc_pkg::ST_RINIT: state_next = wpc_pkg::ST_ROOT;
            wpc_pkg::ST_ROOT: begin
                if (st.root_last) state_next = wpc_pkg::ST_ACC;
            end
            wpc_pkg::ST_ACC:   state_next = wpc_pkg::ST_MODE;
            wpc_pkg::ST_MODE: begin
                priority if (!st.airborne) begin
                    state_next = st.below_takeoff ? wpc_pkg::ST_EM_TO : wpc_pkg::ST_IDLE;
                end else if (st.goal_active) begin
                    state_next = wpc_pkg::ST_GRD;
                end else begin
                    state_next = wpc_pkg::ST_EM_HV;
                end
            end
            wpc_pkg::ST_GRD:   state_next = wpc_pkg::ST_GX;
            wpc_pkg::ST_GX:    state_next = wpc_pkg::ST_GY;
            wpc_pkg::ST_GY:    state_next = wpc_pkg::ST_GZ;
            wpc_pkg::ST_GZ:    state_next = wpc_pkg::ST_GT;
            wpc_pkg::ST_GT:    state_next = wpc_pkg::ST_GE;
            wpc_pkg::ST_GE: begin
                priority if (!st.near) begin
                    state_next = wpc_pkg::ST_DX;
                end else if (st.last_goal) begin
                    state_next = wpc_pkg::ST_EM_HV;
                end else begin
                    state_next = wpc_pkg::ST_GRD2;
                end
            end
            wpc_pkg::ST_GRD2:  state_next = wpc_pkg::ST_DX;
            wpc_pkg::ST_DX:    state_next = wpc_pkg::ST_DY;
            wpc_pkg::ST_DY:    state_next = wpc_pkg::ST_DZ;
            wpc_pkg::ST_DZ:    state_next = wpc_pkg::ST_DE;
            wpc_pkg::ST_DE:    state_next = wpc_pkg::ST_EM_DRV;
            wpc_pkg::ST_EM_TO, wpc_pkg::ST_EM_HV, wpc_pkg::ST_EM_DRV: begin
                if (st.out_free) state_next = wpc_pkg::ST_IDLE;
            end
            default: state_next = wpc_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        cmd = '0;
        cmd.mul_src = wpc_pkg::MS_STEP;
        cmd.emit    = wpc_pkg::EM_NONE;
        unique case (state_reg)
            wpc_pkg::ST_IDLE: cmd.in_ready = 1'b1;
            wpc_pkg::ST_SQX: begin
                cmd.mul_en = 1'b1; cmd.mul_axis = wpc_pkg::AX_X;
            end
            wpc_pkg::ST_SQY: begin
                cmd.mul_en = 1'b1; cmd.mul_axis = wpc_pkg::AX_Y; cmd.acc_load = 1'b1;
            end
            wpc_pkg::ST_SQZ: begin
                cmd.mul_en = 1'b1; cmd.mul_axis = wpc_pkg::AX_Z; cmd.acc_add = 1'b1;
            end
            wpc_pkg::ST_SQE:   cmd.acc_add = 1'b1;
            wpc_pkg::ST_RINIT: cmd.root_init = 1'b1;
            wpc_pkg::ST_ROOT:  cmd.root_step = 1'b1;
            wpc_pkg::ST_ACC:   cmd.upd_sums = 1'b1;
            wpc_pkg::ST_MODE: begin
                cmd.set_airborne = !st.airborne && !st.below_takeoff;
            end
            wpc_pkg::ST_GRD:   cmd.goal_rd = 1'b1;
            wpc_pkg::ST_GX: begin
                cmd.mul_en = 1'b1; cmd.mul_src = wpc_pkg::MS_GOAL;
                cmd.mul_axis = wpc_pkg::AX_X;
            end
            wpc_pkg::ST_GY: begin
                cmd.mul_en = 1'b1; cmd.mul_src = wpc_pkg::MS_GOAL;
                cmd.mul_axis = wpc_pkg::AX_Y; cmd.acc_load = 1'b1;
            end
            wpc_pkg::ST_GZ: begin
                cmd.mul_en = 1'b1; cmd.mul_src = wpc_pkg::MS_GOAL;
                cmd.mul_axis = wpc_pkg::AX_Z; cmd.acc_add = 1'b1;
            end
            wpc_pkg::ST_GT: begin
                cmd.mul_en = 1'b1; cmd.mul_src = wpc_pkg::MS_TOL; cmd.acc_add = 1'b1;
            end
            wpc_pkg::ST_GE: begin
                cmd.adv_ptr  = st.near;
                cmd.set_idle = st.near && st.last_goal;
            end
            wpc_pkg::ST_GRD2:  cmd.goal_rd = 1'b1;
            wpc_pkg::ST_DX: begin
                cmd.mul_en = 1'b1; cmd.mul_src = wpc_pkg::MS_GAIN;
                cmd.mul_axis = wpc_pkg::AX_X;
            end
            wpc_pkg::ST_DY: begin
                cmd.mul_en = 1'b1; cmd.mul_src = wpc_pkg::MS_GAIN;
                cmd.mul_axis = wpc_pkg::AX_Y;
                cmd.drv_store = 1'b1; cmd.store_axis = wpc_pkg::AX_X;
            end
            wpc_pkg::ST_DZ: begin
                cmd.mul_en = 1'b1; cmd.mul_src = wpc_pkg::MS_GAIN;
                cmd.mul_axis = wpc_pkg::AX_Z;
                cmd.drv_store = 1'b1; cmd.store_axis = wpc_pkg::AX_Y;
            end
            wpc_pkg::ST_DE: begin
                cmd.drv_store = 1'b1; cmd.store_axis = wpc_pkg::AX_Z;
            end
            wpc_pkg::ST_EM_TO:  cmd.emit = wpc_pkg::EM_TAKEOFF;
            wpc_pkg::ST_EM_HV:  cmd.emit = wpc_pkg::EM_HOVER;
            wpc_pkg::ST_EM_DRV: cmd.emit = wpc_pkg::EM_DRIVE;
            default: cmd.in_ready = 1'b0;
        endcase
    end
endmodule

@@ hdl/wpc_dpath.sv @@
// Datapath: goal memory, shared multiplier, accumulators and output register.
module wpc_dpath #(
    parameter int MAX_GOALS = wpc_pkg::MAX_GOALS_DEF,
    localparam int CNT_W    = $clog2(MAX_GOALS + 1),
    localparam int IDX_W    = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1,
    localparam int OUT_W    = wpc_pkg::SEQ_W + 3 * wpc_pkg::POS_BITS + 1 + CNT_W
                              + wpc_pkg::DIST_W + wpc_pkg::TIME_W,
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic [wpc_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic [wpc_pkg::OP_W-1:0]          s_tuser,
    input  logic                              cfg_valid,
    input  logic [wpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wpc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              m_tready,
    input  wpc_pkg::cmd_t                     cmd,
    output wpc_pkg::status_t                  st,
    output logic                              m_tvalid,
    output logic [M_DATA_W-1:0]               m_tdata,
    output logic                              m_tuser
);
    localparam int PB = wpc_pkg::POS_BITS;
    localparam int DW = wpc_pkg::DIFF_W;
    localparam int PW = wpc_pkg::PROD_W;
    localparam int RW = wpc_pkg::ROOT_W;
    localparam int GW = 3 * PB;

    // Configuration registers
    logic [wpc_pkg::GAIN_W-1:0] p_gain_reg;
    logic [wpc_pkg::CFG_W-1:0]  max_speed_reg, goal_tol_reg, takeoff_reg;
    logic [wpc_pkg::CFG_W-1:0]  climb_reg, move_thr_reg;

    // Mission state
    logic signed [PB-1:0]       in_pos_reg   [3];
    logic signed [PB-1:0]       last_pos_reg [3];
    logic signed [PB-1:0]       goal_q_reg   [3];
    logic signed [PB-1:0]       drv_reg      [3];
    logic [wpc_pkg::EL_W-1:0]   el_reg;
    logic                       first_reg, airborne_reg, idle_reg;
    logic [CNT_W-1:0]           cnt_reg, ptr_reg;
    logic [wpc_pkg::DIST_W-1:0] dist_reg;
    logic [wpc_pkg::TIME_W-1:0] time_reg;
    logic [wpc_pkg::SEQ_W-1:0]  seq_reg;
    logic [GW-1:0]              goal_mem [MAX_GOALS];

    // Arithmetic
    logic signed [DW-1:0]       step_diff, goal_diff, mul_a, mul_b;
    logic signed [PW-1:0]       prod_reg;
    logic [PW-1:0]              acc_reg;
    logic [RW-1:0]              root;
    logic                       root_last;
    logic signed [PW-1:0]       prod_adj;
    logic signed [DW+9:0]       quot, lim;
    logic signed [PB-1:0]       drv_val;
    logic [wpc_pkg::DIST_W:0]   dist_sum;
    logic [wpc_pkg::TIME_W:0]   time_sum;

    // Output register
    logic                       out_valid_reg, out_to_reg, out_idle_reg;
    logic [wpc_pkg::SEQ_W-1:0]  out_seq_reg;
    logic signed [PB-1:0]       out_mv_reg [3];
    logic [CNT_W-1:0]           out_goal_reg;
    logic [wpc_pkg::DIST_W-1:0] out_dist_reg;
    logic [wpc_pkg::TIME_W-1:0] out_time_reg;

    logic in_acc, out_free, do_emit;

    assign in_acc   = s_tvalid && cmd.in_ready;
    assign out_free = !out_valid_reg || m_tready;
    assign do_emit  = (cmd.emit != wpc_pkg::EM_NONE) && out_free;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gain_reg    <= wpc_pkg::RST_P_GAIN;
            max_speed_reg <= wpc_pkg::RST_MAX_SPEED;
            goal_tol_reg  <= wpc_pkg::RST_GOAL_TOL;
            takeoff_reg   <= wpc_pkg::RST_TAKEOFF_H;
            climb_reg     <= wpc_pkg::RST_CLIMB;
            move_thr_reg  <= wpc_pkg::RST_MOVE_THR;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                wpc_pkg::CFG_P_GAIN:    p_gain_reg    <= cfg_data[wpc_pkg::GAIN_W-1:0];
                wpc_pkg::CFG_MAX_SPEED: max_speed_reg <= cfg_data;
                wpc_pkg::CFG_GOAL_TOL:  goal_tol_reg  <= cfg_data;
                wpc_pkg::CFG_TAKEOFF_H: takeoff_reg   <= cfg_data;
                wpc_pkg::CFG_CLIMB:     climb_reg     <= cfg_data;
                wpc_pkg::CFG_MOVE_THR:  move_thr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture an odometry request
    always_ff @(posedge aclk) begin
        if (in_acc && s_tuser == wpc_pkg::OP_ODOM) begin
            in_pos_reg[0] <= s_tdata[PB-1:0];
            in_pos_reg[1] <= s_tdata[2*PB-1:PB];
            in_pos_reg[2] <= s_tdata[3*PB-1:2*PB];
            el_reg        <= s_tdata[3*PB +: wpc_pkg::EL_W];
        end
    end

    // Goal memory: append at the count, read at the pointer
    always_ff @(posedge aclk) begin
        if (in_acc && s_tuser == wpc_pkg::OP_APPEND && cnt_reg < CNT_W'(MAX_GOALS)) begin
            goal_mem[cnt_reg[IDX_W-1:0]] <= s_tdata[GW-1:0];
        end
        if (cmd.goal_rd) begin
            {goal_q_reg[2], goal_q_reg[1], goal_q_reg[0]} <= goal_mem[ptr_reg[IDX_W-1:0]];
        end
    end

    // Goal list bookkeeping and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            idle_reg     <= 1'b0;
            airborne_reg <= 1'b0;
        end else begin
            if (in_acc && s_tuser == wpc_pkg::OP_APPEND && cnt_reg < CNT_W'(MAX_GOALS)) begin
                cnt_reg  <= cnt_reg + 1'b1;
                idle_reg <= 1'b0;
            end else if (in_acc && s_tuser == wpc_pkg::OP_CLEAR) begin
                cnt_reg  <= '0;
                ptr_reg  <= '0;
                idle_reg <= 1'b0;
            end
            if (cmd.adv_ptr)      ptr_reg      <= ptr_reg + 1'b1;
            if (cmd.set_idle)     idle_reg     <= 1'b1;
            if (cmd.set_airborne) airborne_reg <= 1'b1;
        end
    end

    // Shared multiplier operands
    always_comb begin
        step_diff = DW'(in_pos_reg[cmd.mul_axis]) - DW'(last_pos_reg[cmd.mul_axis]);
        goal_diff = DW'(goal_q_reg[cmd.mul_axis]) - DW'(in_pos_reg[cmd.mul_axis]);
        unique case (cmd.mul_src)
            wpc_pkg::MS_STEP: begin mul_a = step_diff; mul_b = step_diff; end
            wpc_pkg::MS_GOAL: begin mul_a = goal_diff; mul_b = goal_diff; end
            wpc_pkg::MS_TOL: begin
                mul_a = $signed(DW'(goal_tol_reg));
                mul_b = $signed(DW'(goal_tol_reg));
            end
            wpc_pkg::MS_GAIN: begin
                mul_a = goal_diff;
                mul_b = $signed(DW'(p_gain_reg));
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) prod_reg <= mul_a * mul_b;
        if (cmd.acc_load)     acc_reg <= prod_reg;
        else if (cmd.acc_add) acc_reg <= acc_reg + prod_reg;
    end

    wpc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .init     (cmd.root_init),
        .step     (cmd.root_step),
        .radicand (acc_reg),
        .root     (root),
        .last     (root_last)
    );

    // Saturating path and moving-time sums
    assign dist_sum = {1'b0, dist_reg} + (wpc_pkg::DIST_W + 1)'(root);
    assign time_sum = {1'b0, time_reg} + (wpc_pkg::TIME_W + 1)'(el_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            dist_reg  <= '0;
            time_reg  <= '0;
            for (int i = 0; i < 3; i++) last_pos_reg[i] <= '0;
        end else if (cmd.upd_sums) begin
            if (!first_reg) begin
                dist_reg <= dist_sum[wpc_pkg::DIST_W] ? '1 : dist_sum[wpc_pkg::DIST_W-1:0];
                if (root > RW'(move_thr_reg)) begin
                    time_reg <= time_sum[wpc_pkg::TIME_W] ? '1
                                                          : time_sum[wpc_pkg::TIME_W-1:0];
                end
            end
            for (int i = 0; i < 3; i++) last_pos_reg[i] <= in_pos_reg[i];
            first_reg <= 1'b0;
        end
    end

    // Drive command: truncate toward zero, then clamp
    always_comb begin
        prod_adj = prod_reg + (prod_reg[PW-1] ? PW'(255) : PW'(0));
        quot     = (DW + 10)'(prod_adj >>> 8);
        lim      = $signed((DW + 10)'(max_speed_reg));
        priority if (quot > lim)  drv_val = PB'(lim);
        else if (quot < -lim)     drv_val = PB'(-lim);
        else                      drv_val = PB'(quot);
    end

    always_ff @(posedge aclk) begin
        if (cmd.drv_store) drv_reg[cmd.store_axis] <= drv_val;
    end

    // Command counter and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (do_emit) begin
                seq_reg       <= seq_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            out_seq_reg  <= seq_reg + 1'b1;
            out_idle_reg <= idle_reg;
            out_goal_reg <= ptr_reg;
            out_dist_reg <= dist_reg;
            out_time_reg <= time_reg;
            out_to_reg   <= (cmd.emit == wpc_pkg::EM_TAKEOFF);
            unique case (cmd.emit)
                wpc_pkg::EM_TAKEOFF: begin
                    out_mv_reg[0] <= '0;
                    out_mv_reg[1] <= '0;
                    out_mv_reg[2] <= PB'(climb_reg);
                end
                wpc_pkg::EM_DRIVE: begin
                    for (int i = 0; i < 3; i++) out_mv_reg[i] <= drv_reg[i];
                end
                default: begin
                    for (int i = 0; i < 3; i++) out_mv_reg[i] <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_to_reg;
    assign m_tdata  = M_DATA_W'({out_time_reg, out_dist_reg, out_goal_reg, out_idle_reg,
                                 out_mv_reg[2], out_mv_reg[1], out_mv_reg[0], out_seq_reg});

    // Status toward the sequencer
    always_comb begin
        st.odom_req      = in_acc && (s_tuser == wpc_pkg::OP_ODOM);
        st.first_sample  = first_reg;
        st.airborne      = airborne_reg;
        st.below_takeoff = $signed(DW'(in_pos_reg[2])) < $signed(DW'(takeoff_reg));
        st.goal_active   = (cnt_reg != '0) && (ptr_reg < cnt_reg);
        st.near          = acc_reg < $unsigned(prod_reg);
        st.last_goal     = ({1'b0, ptr_reg} + 1'b1) >= {1'b0, cnt_reg};
        st.out_free      = out_free;
        st.root_last     = root_last;
        st.ptr_ok        = ptr_reg <= cnt_reg;
    end
endmodule
